>>> design/dws_pkg.sv
package dws_pkg;

	localparam int DEPTH = 32;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	typedef logic [IW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_DUMP       = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_POP_BACK   = 3'd4,
		OP_SEARCH     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic    walk_start;
		logic    walk_next;
		logic    rd_pop;
		logic    do_push;
		logic    do_pop;
		logic    emit;
		status_t status;
		logic    found;
		logic    use_data;
		logic    last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       empty;
		logic       walk_last;
		logic       hit;
		logic       out_free;
	} sts_t;

	// ring slot of an offset from the front, both below DEPTH
	function automatic idx_t slot(input idx_t front, input idx_t off);
		logic [IW:0] sum;
		sum = {1'b0, front} + {1'b0, off};
		if (sum >= (IW+1)'(DEPTH)) begin
			sum = sum - (IW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

endpackage

>>> design/dws_ctrl.sv
module dws_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  dws_pkg::sts_t sts,
	output dws_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_POP  = 5'b00100,
		S_DUMP = 5'b01000,
		S_SRCH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = dws_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.op)
					dws_pkg::OP_PUSH_FRONT, dws_pkg::OP_PUSH_BACK: begin
						if (sts.out_free) begin
							cmd.emit    = 1'b1;
							cmd.last    = 1'b1;
							cmd.status  = sts.full ? dws_pkg::ST_FULL : dws_pkg::ST_OK;
							cmd.do_push = !sts.full;
							state_d     = S_IDLE;
						end
					end
					dws_pkg::OP_POP_FRONT, dws_pkg::OP_POP_BACK: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.emit   = 1'b1;
								cmd.last   = 1'b1;
								cmd.status = dws_pkg::ST_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							cmd.rd_pop = 1'b1;
							state_d    = S_POP;
						end
					end
					dws_pkg::OP_DUMP: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.emit   = 1'b1;
								cmd.last   = 1'b1;
								cmd.status = dws_pkg::ST_EMPTY;
								state_d    = S_IDLE;
							end
						end else begin
							cmd.walk_start = 1'b1;
							state_d        = S_DUMP;
						end
					end
					dws_pkg::OP_SEARCH: begin
						if (sts.empty) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								state_d  = S_IDLE;
							end
						end else begin
							cmd.walk_start = 1'b1;
							state_d        = S_SRCH;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_POP: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.last     = 1'b1;
					cmd.use_data = 1'b1;
					cmd.do_pop   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_DUMP: begin
				if (sts.out_free) begin
					cmd.emit     = 1'b1;
					cmd.use_data = 1'b1;
					cmd.last     = sts.walk_last;
					if (sts.walk_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk_next = 1'b1;
					end
				end
			end
			S_SRCH: begin
				if (sts.hit || sts.walk_last) begin
					if (sts.out_free) begin
						cmd.emit  = 1'b1;
						cmd.last  = 1'b1;
						cmd.found = sts.hit;
						state_d   = S_IDLE;
					end
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("word emitted while output register busy");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_push |-> !sts.full)
		else $error("push into full store");

	a_read_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_pop || cmd.walk_start || cmd.walk_next) |-> !sts.empty)
		else $error("store read while empty");

endmodule

>>> design/dws_dp.sv
module dws_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_accept,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  value,
	input  dws_pkg::cmd_t       cmd,
	output dws_pkg::sts_t       sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                found,
	output logic signed [31:0]  data,
	output logic                last
);

	logic [2:0]          op_q;
	logic signed [31:0]  val_q;
	dws_pkg::idx_t       front_q;
	dws_pkg::cnt_t       count_q;
	dws_pkg::idx_t       idx_q;
	logic signed [31:0]  rdata_s1;
	logic signed [31:0]  mem_q [dws_pkg::DEPTH];

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic                found_q;
	logic signed [31:0]  data_q;
	logic                last_q;

	dws_pkg::idx_t       rd_off;
	dws_pkg::idx_t       rd_addr;
	logic                rd_en;
	dws_pkg::idx_t       front_dec;
	dws_pkg::idx_t       front_inc;
	dws_pkg::idx_t       wr_addr;
	logic                push_front;
	logic                pop_front;

	assign push_front = (op_q == dws_pkg::OP_PUSH_FRONT);
	assign pop_front  = (op_q == dws_pkg::OP_POP_FRONT);

	assign front_dec = (front_q == '0) ? dws_pkg::IW'(dws_pkg::DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == dws_pkg::IW'(dws_pkg::DEPTH - 1)) ? '0 : front_q + 1'b1;

	always_comb begin
		priority if (cmd.walk_start) begin
			rd_off = '0;
		end else if (cmd.walk_next) begin
			rd_off = idx_q + 1'b1;
		end else if (pop_front) begin
			rd_off = '0;
		end else begin
			rd_off = dws_pkg::IW'(count_q - 1'b1);
		end
	end

	assign rd_en   = cmd.walk_start || cmd.walk_next || cmd.rd_pop;
	assign rd_addr = dws_pkg::slot(front_q, rd_off);
	assign wr_addr = push_front ? front_dec
	                            : dws_pkg::slot(front_q, dws_pkg::IW'(count_q));

	assign sts.op        = op_q;
	assign sts.full      = (count_q == dws_pkg::CW'(dws_pkg::DEPTH));
	assign sts.empty     = (count_q == '0);
	assign sts.walk_last = ((dws_pkg::CW'(idx_q) + 1'b1) == count_q);
	assign sts.hit       = (rdata_s1 == val_q);
	assign sts.out_free  = !out_valid_q || out_ready;

	// item word
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= opcode;
			val_q <= value;
		end
	end

	// ring store
	always_ff @(posedge clk) begin
		if (cmd.do_push) begin
			mem_q[wr_addr] <= val_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start || cmd.walk_next) begin
			idx_q <= rd_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.do_push) begin
			count_q <= count_q + 1'b1;
			if (push_front) begin
				front_q <= front_dec;
			end
		end else if (cmd.do_pop) begin
			count_q <= count_q - 1'b1;
			if (pop_front) begin
				front_q <= front_inc;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.status;
			found_q  <= cmd.found;
			data_q   <= cmd.use_data ? rdata_s1 : '0;
			last_q   <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign data      = data_q;
	assign last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dws_pkg::CW'(dws_pkg::DEPTH))
		else $error("entry count above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= dws_pkg::IW'(dws_pkg::DEPTH - 1))
		else $error("front index outside ring");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_push |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow the store");

endmodule

>>> design/deque_with_search.sv
// push answers at decode; pop reads the store, then answers; search walks until hit or last
// dump: words come from the store read port, one per cycle while the output register is free
// throughput: one item at a time; the single read port of the ring store sets the walk rate
// in_ready rises again once the last word of an item sits in the output register
// reset: arst_n asynchronous, active low; empties the store, front index to zero
module deque_with_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          opcode,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                found,
	output logic signed [31:0]  data,
	output logic                last
);

	dws_pkg::cmd_t cmd;
	dws_pkg::sts_t sts;
	logic          in_accept;

	assign in_accept = in_valid && in_ready;

	dws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.opcode    (opcode),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.found     (found),
		.data      (data),
		.last      (last)
	);

endmodule

>>> bench/tb_deque_with_search.sv
module tb_deque_with_search;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS       = 470;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] val;
	} req_t;

	typedef struct {
		dws_pkg::status_t   status;
		logic               found;
		logic signed [31:0] data;
		logic               last;
	} resp_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [2:0]         opcode    = '0;
	logic signed [31:0] value     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic               found;
	logic signed [31:0] data;
	logic               last;

	deque_with_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.found     (found),
		.data      (data),
		.last      (last)
	);

	// predicted deque contents
	logic signed [31:0] ring [dws_pkg::DEPTH];
	dws_pkg::idx_t      head = '0;
	dws_pkg::cnt_t      fill = '0;
	resp_t              want_q[$];

	// stimulus plan and its view of the deque
	req_t               pending[$];
	logic signed [31:0] plan[$];
	int                 planned_items = 0;
	int                 total_items   = 0;

	int    sent_items   = 0;
	int    words_seen   = 0;
	int    errors       = 0;
	int    n_full       = 0;
	int    n_empty      = 0;
	int    n_hits       = 0;
	int    in_pause     = 0;
	int    out_stall    = 0;
	int    idle_cycles  = 0;
	bit    in_burst     = 1'b0;
	bit    out_burst    = 1'b0;
	req_t  nxt;
	resp_t got_w;

	function automatic dws_pkg::idx_t ring_slot(input int off);
		return dws_pkg::idx_t'((int'(head) + off) % dws_pkg::DEPTH);
	endfunction

	task automatic apply_deque_op(input logic [2:0] op, input logic signed [31:0] v);
		resp_t r;
		bit    hit;
		r   = '{dws_pkg::ST_OK, 1'b0, 32'sd0, 1'b1};
		hit = 1'b0;
		case (op)
		dws_pkg::OP_PUSH_FRONT, dws_pkg::OP_PUSH_BACK: begin
			if (fill == dws_pkg::cnt_t'(dws_pkg::DEPTH)) begin
				r.status = dws_pkg::ST_FULL;
				n_full++;
			end else if (op == dws_pkg::OP_PUSH_FRONT) begin
				head = dws_pkg::idx_t'((int'(head) + dws_pkg::DEPTH - 1) % dws_pkg::DEPTH);
				ring[head] = v;
				fill++;
			end else begin
				ring[ring_slot(int'(fill))] = v;
				fill++;
			end
			want_q.push_back(r);
		end
		dws_pkg::OP_DUMP: begin
			if (fill == 0) begin
				r.status = dws_pkg::ST_EMPTY;
				n_empty++;
				want_q.push_back(r);
			end else begin
				for (int i = 0; i < int'(fill); i++) begin
					r.data = ring[ring_slot(i)];
					r.last = (i == int'(fill) - 1);
					want_q.push_back(r);
				end
			end
		end
		dws_pkg::OP_POP_FRONT, dws_pkg::OP_POP_BACK: begin
			if (fill == 0) begin
				r.status = dws_pkg::ST_EMPTY;
				n_empty++;
			end else if (op == dws_pkg::OP_POP_FRONT) begin
				r.data = ring[head];
				head = dws_pkg::idx_t'((int'(head) + 1) % dws_pkg::DEPTH);
				fill--;
			end else begin
				fill--;
				r.data = ring[ring_slot(int'(fill))];
			end
			want_q.push_back(r);
		end
		dws_pkg::OP_SEARCH: begin
			for (int i = 0; i < int'(fill); i++) begin
				if (ring[ring_slot(i)] == v) begin
					hit = 1'b1;
				end
			end
			r.found = hit;
			if (hit) begin
				n_hits++;
			end
			want_q.push_back(r);
		end
		default: ;
		endcase
	endtask

	task automatic plan_item(input logic [2:0] op, input logic signed [31:0] v);
		req_t q;
		q.op  = op;
		q.val = v;
		pending.push_back(q);
		if (op <= dws_pkg::OP_SEARCH) begin
			planned_items++;
		end
		case (op)
		dws_pkg::OP_PUSH_FRONT: if (plan.size() < dws_pkg::DEPTH) begin
			plan.push_front(v);
		end
		dws_pkg::OP_PUSH_BACK: if (plan.size() < dws_pkg::DEPTH) begin
			plan.push_back(v);
		end
		dws_pkg::OP_POP_FRONT: if (plan.size() != 0) begin
			void'(plan.pop_front());
		end
		dws_pkg::OP_POP_BACK: if (plan.size() != 0) begin
			void'(plan.pop_back());
		end
		default: ;
		endcase
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
		0: begin
			case ($urandom_range(0, 3))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return 32'sd0;
			default: return -32'sd1;
			endcase
		end
		1, 2: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
		default: return $signed($urandom);
		endcase
	endfunction

	// half the probes look for something that is stored
	function automatic logic signed [31:0] pick_probe();
		if (plan.size() != 0 && $urandom_range(0, 1) == 1) begin
			return plan[$urandom_range(0, plan.size() - 1)];
		end
		return pick_value();
	endfunction

	function automatic logic [2:0] pick_op(input int push_w, input int pop_w);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_w) begin
			return $urandom_range(0, 1) ? dws_pkg::OP_PUSH_BACK : dws_pkg::OP_PUSH_FRONT;
		end
		if (r < push_w + pop_w) begin
			return $urandom_range(0, 1) ? dws_pkg::OP_POP_BACK : dws_pkg::OP_POP_FRONT;
		end
		if (r < push_w + pop_w + 12) begin
			return dws_pkg::OP_SEARCH;
		end
		return dws_pkg::OP_DUMP;
	endfunction

	task automatic plan_random(input logic [2:0] op);
		if (op == dws_pkg::OP_PUSH_FRONT || op == dws_pkg::OP_PUSH_BACK) begin
			plan_item(op, pick_value());
		end else if (op == dws_pkg::OP_SEARCH) begin
			plan_item(op, pick_probe());
		end else begin
			plan_item(op, $signed($urandom));
		end
	endtask

	function automatic int draw_pause(input bit burst);
		return burst ? 0 : $urandom_range(0, 15);
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				apply_deque_op(opcode, value);
				sent_items++;
			end
			if (!in_valid || in_ready) begin
				if (in_pause > 0) begin
					in_pause--;
					in_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					nxt = pending.pop_front();
					opcode   <= nxt.op;
					value    <= nxt.val;
					in_valid <= 1'b1;
					if ($urandom_range(0, 19) == 0) begin
						in_burst = !in_burst;
					end
					in_pause = draw_pause(in_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				words_seen++;
				if (want_q.size() == 0) begin
					$display("%0t: unexpected word, expected none", $time);
					$display("%0t:   actual status=%0d found=%0d data=%0d last=%0d",
						$time, status, found, data, last);
					errors++;
				end else begin
					got_w = want_q.pop_front();
					if (status !== got_w.status || found !== got_w.found ||
							data !== got_w.data || last !== got_w.last) begin
						$display("%0t: expected status=%0d found=%0d data=%0d last=%0d",
							$time, got_w.status, got_w.found, got_w.data, got_w.last);
						$display("%0t:   actual status=%0d found=%0d data=%0d last=%0d",
							$time, status, found, data, last);
						errors++;
					end
				end
				if ($urandom_range(0, 19) == 0) begin
					out_burst = !out_burst;
				end
				out_stall = draw_pause(out_burst);
			end else if (out_stall > 0) begin
				out_stall--;
			end
			out_ready <= (out_stall == 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("deque_with_search: mismatch");
			$finish;
		end
	end

	initial begin
		int phase;
		int kind;
		int n;

		// empty store corners
		plan_item(dws_pkg::OP_DUMP, 32'sd0);
		plan_item(dws_pkg::OP_POP_FRONT, 32'sd0);
		plan_item(dws_pkg::OP_POP_BACK, -32'sd1);
		plan_item(dws_pkg::OP_SEARCH, 32'sd0);
		// extremes in both ends
		plan_item(dws_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
		plan_item(dws_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
		plan_item(dws_pkg::OP_PUSH_BACK, 32'sd0);
		plan_item(dws_pkg::OP_PUSH_FRONT, -32'sd1);
		plan_item(dws_pkg::OP_PUSH_BACK, 32'sd1);
		plan_item(dws_pkg::OP_SEARCH, 32'sh8000_0000);
		plan_item(dws_pkg::OP_SEARCH, 32'sh1234_5678);
		plan_item(dws_pkg::OP_SEARCH, 32'sh7fff_ffff);
		plan_item(dws_pkg::OP_DUMP, 32'sd0);
		// unused opcodes are dropped
		plan_item(3'd6, 32'sh5555_aaaa);
		plan_item(3'd7, -32'sd1);
		plan_item(dws_pkg::OP_POP_FRONT, 32'sd0);
		plan_item(dws_pkg::OP_POP_BACK, 32'sd0);
		plan_item(dws_pkg::OP_POP_FRONT, 32'sd0);
		plan_item(dws_pkg::OP_POP_BACK, 32'sd0);
		plan_item(dws_pkg::OP_POP_FRONT, 32'sd0);
		plan_item(dws_pkg::OP_POP_BACK, 32'sd0);
		plan_item(dws_pkg::OP_DUMP, 32'sd0);
		plan_item(dws_pkg::OP_PUSH_FRONT, 32'sd5);
		plan_item(dws_pkg::OP_DUMP, 32'sd0);

		phase = 0;
		while (planned_items < ITEMS) begin
			kind = (phase < 2) ? phase : $urandom_range(0, 2);
			case (kind)
			0: begin
				// fill up, then push against the full store
				while (plan.size() < dws_pkg::DEPTH) begin
					plan_random(pick_op(72, 10));
				end
				n = $urandom_range(1, 3);
				repeat (n) plan_random(pick_op(100, 0));
				if ($urandom_range(0, 1) == 1) begin
					plan_item(dws_pkg::OP_DUMP, 32'sd0);
				end
			end
			1: begin
				// drain, then pop the empty store, then search or dump it
				while (plan.size() != 0) begin
					plan_random(pick_op(12, 72));
				end
				n = $urandom_range(1, 3);
				repeat (n) plan_random(pick_op(0, 100));
				plan_random(pick_op(0, 0));
			end
			default: begin
				n = $urandom_range(10, 30);
				repeat (n) begin
					if ($urandom_range(0, 31) == 0) begin
						plan_item(3'($urandom_range(6, 7)), $signed($urandom));
					end else begin
						plan_random(pick_op(32, 30));
					end
				end
			end
			endcase
			phase++;
		end
		total_items = pending.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_items != total_items) @(posedge clk);
		while (want_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d input words sent, %0d result words checked", sent_items, words_seen);
		$display("%0d pushes refused as full, %0d empty responses, %0d search hits",
			n_full, n_empty, n_hits);
		if (errors == 0) begin
			$display("deque_with_search: match");
		end else begin
			$display("deque_with_search: mismatch");
		end
		$finish;
	end

endmodule
